// ----- src/dma_transfer_descriptor_builder_defines.svh -----
// Assertion macros shared by the descriptor builder modules.
`ifndef DMA_TRANSFER_DESCRIPTOR_BUILDER_DEFINES_SVH
`define DMA_TRANSFER_DESCRIPTOR_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define DTDB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define DTDB_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define DTDB_ASSERT(label, clk, rst, prop, msg)
`define DTDB_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- src/dtdb_pkg.sv -----
// Types, codes and constants of the DMA transfer descriptor builder.
package dtdb_pkg;

  localparam int FRAME_LIMIT_DEF = 256;

  localparam int BYTES_W = 32;
  localparam int DIV_CNT_W = $clog2(BYTES_W);

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Address adjust modes.
  localparam logic [1:0] ADJ_INC   = 2'd0;
  localparam logic [1:0] ADJ_DEC   = 2'd1;
  localparam logic [1:0] ADJ_FIXED = 2'd2;
  localparam logic [1:0] ADJ_RSVD  = 2'd3;

  // Last supported transfer direction (peripheral to memory).
  localparam logic [2:0] DIR_PERIPH_TO_MEM = 3'd2;

  // Element size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [4:0] REQ_SEL_MASK = 5'h1F;

  typedef struct packed {
    logic [3:0]  num_blocks;
    logic        extra_features;
    logic [2:0]  transfer_direction;
    logic [7:0]  source_width;
    logic [7:0]  dest_width;
    logic [31:0] block_bytes;
    logic [1:0]  source_adjust;
    logic [1:0]  dest_adjust;
    logic        cyclic;
    logic [7:0]  request_slot;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } dtdb_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_count_less_one;
    logic [7:0]  pack_count_less_one;
    logic        packed_mode;
    logic [1:0]  size_code;
    logic        source_fixed;
    logic        dest_fixed;
    logic        continuous;
    logic [4:0]  request_select;
    logic [31:0] source_addr_out;
    logic [31:0] dest_addr_out;
  } dtdb_result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EVAL,
    S_SEARCH,
    S_FIN
  } dtdb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic srch_init;
    logic srch_step;
    logic finish;
  } dtdb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_fail;
    logic div_last;
    logic div_bad;
    logic single;
    logic srch_hit;
    logic srch_fail;
  } dtdb_stat_t;

endpackage

// ----- src/dtdb_ctrl.sv -----
// Sequencing controller of the descriptor builder.
`include "dma_transfer_descriptor_builder_defines.svh"

module dtdb_ctrl
  import dtdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dtdb_stat_t stat,
  output dtdb_cmd_t  cmd
);

  dtdb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // Field checks that need no arithmetic decide early failures.
        state_next = stat.pre_fail ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.div_bad || stat.single) begin
          state_next = S_FIN;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.srch_hit || stat.srch_fail) begin
          state_next = S_FIN;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  `DTDB_ASSERT(a_fin_returns, clk, rst, (state == S_FIN) |=> (state == S_IDLE), "finish did not return to idle")
  `DTDB_ASSERT(a_div_holds, clk, rst, (state == S_DIV) && !stat.div_last |=> (state == S_DIV), "division left early")
  `DTDB_ASSERT(a_hit_ends, clk, rst, (state == S_SEARCH) && stat.srch_hit |=> (state == S_FIN), "search hit not finished")

endmodule

// ----- src/dtdb_dpath.sv -----
// Datapath of the descriptor builder: checks, bit-serial divider and factor search.
`include "dma_transfer_descriptor_builder_defines.svh"

module dtdb_dpath
  import dtdb_pkg::*;
#(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
)(
  input  logic         clk,
  input  logic         rst,
  input  dtdb_req_t    req,
  input  dtdb_cmd_t    cmd,
  output dtdb_stat_t   stat,
  output logic         done,
  output dtdb_result_t result
);

  localparam int CNT_W  = $clog2(FRAME_LIMIT + 1);
  localparam int PROD_W = 2 * CNT_W;

  dtdb_req_t             req_q;
  logic [BYTES_W-1:0]    quo;
  logic [7:0]            rem;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [CNT_W-1:0]      d;
  logic [CNT_W-1:0]      q;
  logic [PROD_W-1:0]     p;

  logic [8:0]            trial;
  logic                  trial_ge;
  logic [1:0]            pre_status;
  logic                  below;
  logic                  hit;
  logic [1:0]            size_c;
  logic                  size_bad;
  logic                  adj_bad;
  logic [1:0]            status_c;
  dtdb_result_t          result_next;

  // Restoring division, one quotient bit per step.
  assign trial    = {rem, quo[BYTES_W-1]};
  assign trial_ge = (trial >= {1'b0, req_q.source_width});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req;
      quo     <= req.block_bytes;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? 8'(trial - {1'b0, req_q.source_width}) : trial[7:0];
      quo     <= {quo[BYTES_W-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Factor search: d walks down from the limit, q up from one, p tracks d * q.
  assign below = (BYTES_W'(p) < quo);
  assign hit   = (BYTES_W'(p) == quo);

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      d <= CNT_W'(FRAME_LIMIT);
      q <= CNT_W'(1);
      p <= PROD_W'(FRAME_LIMIT);
    end else if (cmd.srch_step) begin
      if (below) begin
        q <= q + 1'b1;
        p <= p + PROD_W'(d);
      end else begin
        d <= d - 1'b1;
        p <= p - PROD_W'(q);
      end
    end
  end

  always_comb begin
    if (req_q.num_blocks != 4'd1) begin
      pre_status = ST_INVALID;
    end else if (req_q.extra_features) begin
      pre_status = ST_UNSUPPORTED;
    end else if (req_q.transfer_direction > DIR_PERIPH_TO_MEM) begin
      pre_status = ST_UNSUPPORTED;
    end else if ((req_q.source_width == 8'd0) ||
                 (req_q.source_width != req_q.dest_width)) begin
      pre_status = ST_UNSUPPORTED;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign stat.pre_fail  = (pre_status != ST_OK);
  assign stat.div_last  = (div_cnt == DIV_CNT_W'(BYTES_W - 1));
  assign stat.div_bad   = (req_q.block_bytes == '0) || (rem != 8'd0);
  assign stat.single    = (quo <= BYTES_W'(FRAME_LIMIT));
  assign stat.srch_hit  = hit;
  assign stat.srch_fail = (below && (q == CNT_W'(FRAME_LIMIT))) ||
                          (!below && !hit && (d == CNT_W'(1)));

  always_comb begin
    size_bad = 1'b0;
    case (req_q.source_width)
      8'd1:    size_c = SIZE_BYTE;
      8'd2:    size_c = SIZE_HALF;
      8'd4:    size_c = SIZE_WORD;
      default: begin
        size_c   = SIZE_BYTE;
        size_bad = 1'b1;
      end
    endcase
  end

  assign adj_bad = (req_q.source_adjust == ADJ_DEC) || (req_q.source_adjust == ADJ_RSVD) ||
                   (req_q.dest_adjust == ADJ_DEC) || (req_q.dest_adjust == ADJ_RSVD);

  always_comb begin
    if (pre_status != ST_OK) begin
      status_c = pre_status;
    end else if (stat.div_bad) begin
      status_c = ST_INVALID;
    end else if (!stat.single && !hit) begin
      status_c = ST_UNSUPPORTED;
    end else if (size_bad) begin
      status_c = ST_INVALID;
    end else if (adj_bad) begin
      status_c = ST_UNSUPPORTED;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    result_next = '0;
    result_next.status = status_c;
    if (status_c == ST_OK) begin
      if (stat.single) begin
        result_next.frame_count_less_one = 8'(quo - 1'b1);
        result_next.pack_count_less_one  = 8'd0;
        result_next.packed_mode          = 1'b0;
      end else begin
        result_next.frame_count_less_one = 8'(q - 1'b1);
        result_next.pack_count_less_one  = 8'(d - 1'b1);
        result_next.packed_mode          = 1'b1;
      end
      result_next.size_code       = size_c;
      result_next.source_fixed    = (req_q.source_adjust == ADJ_FIXED);
      result_next.dest_fixed      = (req_q.dest_adjust == ADJ_FIXED);
      result_next.continuous      = req_q.cyclic;
      result_next.request_select  = req_q.request_slot[4:0] & REQ_SEL_MASK;
      result_next.source_addr_out = req_q.source_addr;
      result_next.dest_addr_out   = req_q.dest_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= result_next;
    end
  end

  `DTDB_ASSERT(a_done_after_fin, clk, rst, done |-> $past(cmd.finish), "result strobe without finish")
  `DTDB_ASSERT(a_err_zero, clk, rst, done && (result.status != ST_OK) |-> (result.frame_count_less_one == 8'd0) && (result.packed_mode == 1'b0) && (result.dest_addr_out == '0), "error result carries data")
  `DTDB_ASSERT(a_q_monotone, clk, rst, cmd.srch_step |=> (q >= $past(q)), "frame count went down in search")

endmodule

// ----- src/dma_transfer_descriptor_builder.sv -----
// Top level of the DMA transfer descriptor builder.
//
// The block checks one single-block transfer request and builds the length,
// size and address-mode fields of a channel descriptor. A transaction is taken
// from req at a rising edge where start is high and busy is low. Busy stays high
// while the request is worked on, and one result transaction per request is
// shown on result for exactly one cycle with done high; the receiver cannot
// stall it, so it must take the result in that cycle.
// Sequence, from the accepting edge to the edge that raises done: a request
// that fails a field check goes through the check state, then the finish state.
// Otherwise the byte count goes through a bit-serial divider over all 32 bits,
// an evaluate step judges the quotient, and an element count above
// FRAME_LIMIT is then factored by a walk that moves one of its two counters per
// cycle, before the finish state.
// One request is in flight at a time; the next may start in the cycle done is
// shown. Reset clears the controller to idle and drops done; no clearing pass.
module dma_transfer_descriptor_builder
  import dtdb_pkg::*;
#(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
)(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  dtdb_req_t    req,
  output logic         done,
  output dtdb_result_t result
);

  dtdb_cmd_t  cmd;
  dtdb_stat_t stat;

  // The controller steps through check, divide, evaluate, search and finish.
  dtdb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the request, the divider, the factor search and the
  // result register.
  dtdb_dpath #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the DMA transfer descriptor builder.
module tb_top;
  import dtdb_pkg::*;

  // The block is built with its default frame limit, and the local predictor
  // uses the same value.
  localparam int FRAME_LIMIT = FRAME_LIMIT_DEF;
  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP = 8;
  localparam int RANDOM_ITEMS = 556;
  localparam int MAX_REPORTS = 10;

  // After the last result we wait longer than the slowest request takes from
  // the accepting edge until done is raised, to catch a stray done. The
  // watchdog allows several times the slowest transaction plus the longest
  // sender gap.
  localparam int TAIL_CYCLES = 2 * FRAME_LIMIT + 40;
  localparam int WD_LIMIT = 4 * (2 * FRAME_LIMIT + 36 + MAX_GAP);

  // Codes that the package does not name.
  localparam logic [3:0] SINGLE_BLOCK      = 4'd1;
  localparam logic [2:0] DIR_MEM_TO_MEM    = 3'd0;
  localparam logic [2:0] DIR_MEM_TO_PERIPH = 3'd1;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic         busy;
  dtdb_req_t    req;
  logic         done;
  dtdb_result_t result;

  dma_transfer_descriptor_builder #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Descriptors that the block still owes us, oldest first.
  dtdb_result_t pending_descriptors[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int           steady_left = 0;

  // One row of the directed table. Where typed is set, the expected
  // descriptor is written into the row; otherwise the predictor supplies it.
  typedef struct packed {
    dtdb_req_t    rq;
    logic         typed;
    dtdb_result_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // ---------------------------------------------------------------------------
  // Predictor: the checks run in a fixed order and the first failure decides
  // the status. A failed request returns a descriptor that is zero apart from
  // its status.
  // ---------------------------------------------------------------------------
  function automatic dtdb_result_t build_descriptor(input dtdb_req_t rq);
    dtdb_result_t d;
    logic [31:0]  elems;
    logic [31:0]  frames;
    logic [31:0]  packs;
    logic         fits;
    logic [1:0]   size;
    d = '0;
    if (rq.num_blocks != SINGLE_BLOCK) begin
      d.status = ST_INVALID;
      return d;
    end
    if (rq.extra_features) begin
      d.status = ST_UNSUPPORTED;
      return d;
    end
    if (rq.transfer_direction > DIR_PERIPH_TO_MEM) begin
      d.status = ST_UNSUPPORTED;
      return d;
    end
    if (rq.source_width == 8'd0 || rq.source_width != rq.dest_width) begin
      d.status = ST_UNSUPPORTED;
      return d;
    end
    if (rq.block_bytes == 32'd0 || (rq.block_bytes % rq.source_width) != 32'd0) begin
      d.status = ST_INVALID;
      return d;
    end
    elems = rq.block_bytes / rq.source_width;

    // Short counts fit into one frame. Longer ones are split as
    // frames x packs, taking the largest pack count that leaves a legal frame.
    fits = 1'b0;
    frames = 32'd0;
    packs = 32'd0;
    if (elems <= FRAME_LIMIT) begin
      fits = 1'b1;
      frames = elems;
      packs = 32'd1;
    end else begin
      for (int div = FRAME_LIMIT; div >= 1; div--) begin
        if (!fits && (elems % div) == 0 && (elems / div) <= FRAME_LIMIT) begin
          fits = 1'b1;
          frames = elems / div;
          packs = div;
        end
      end
    end
    if (!fits) begin
      d.status = ST_UNSUPPORTED;
      return d;
    end

    // The width check comes after the split, so an odd width whose count
    // cannot be split reports the split failure.
    case (rq.source_width)
      8'd1: size = SIZE_BYTE;
      8'd2: size = SIZE_HALF;
      8'd4: size = SIZE_WORD;
      default: begin
        d.status = ST_INVALID;
        return d;
      end
    endcase
    if ((rq.source_adjust != ADJ_INC && rq.source_adjust != ADJ_FIXED) ||
        (rq.dest_adjust != ADJ_INC && rq.dest_adjust != ADJ_FIXED)) begin
      d.status = ST_UNSUPPORTED;
      return d;
    end

    d.status               = ST_OK;
    d.frame_count_less_one = 8'(frames - 32'd1);
    d.pack_count_less_one  = 8'(packs - 32'd1);
    d.packed_mode          = (elems > FRAME_LIMIT);
    d.size_code            = size;
    d.source_fixed         = (rq.source_adjust == ADJ_FIXED);
    d.dest_fixed           = (rq.dest_adjust == ADJ_FIXED);
    d.continuous           = rq.cyclic;
    d.request_select       = rq.request_slot[4:0] & REQ_SEL_MASK;
    d.source_addr_out      = rq.source_addr;
    d.dest_addr_out        = rq.dest_addr;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers for building requests and typed descriptors of the directed table.
  // ---------------------------------------------------------------------------
  function automatic dtdb_req_t req_of(input logic [3:0] bc, input logic extra,
                                       input logic [2:0] dir, input logic [7:0] sw,
                                       input logic [7:0] dw, input logic [31:0] bytes,
                                       input logic [1:0] sadj, input logic [1:0] dadj,
                                       input logic cyc, input logic [7:0] slot,
                                       input logic [31:0] saddr, input logic [31:0] daddr);
    dtdb_req_t rq;
    rq.num_blocks         = bc;
    rq.extra_features     = extra;
    rq.transfer_direction = dir;
    rq.source_width       = sw;
    rq.dest_width         = dw;
    rq.block_bytes        = bytes;
    rq.source_adjust      = sadj;
    rq.dest_adjust        = dadj;
    rq.cyclic             = cyc;
    rq.request_slot       = slot;
    rq.source_addr        = saddr;
    rq.dest_addr          = daddr;
    return rq;
  endfunction

  function automatic dtdb_result_t rejected(input logic [1:0] st);
    dtdb_result_t d;
    d = '0;
    d.status = st;
    return d;
  endfunction

  function automatic dtdb_result_t accepted_desc(input logic [7:0] flen, input logic [1:0] size,
                                                 input logic sfix, input logic dfix,
                                                 input logic cont, input logic [4:0] sel,
                                                 input logic [31:0] saddr,
                                                 input logic [31:0] daddr);
    dtdb_result_t d;
    d = '0;
    d.status               = ST_OK;
    d.frame_count_less_one = flen;
    d.size_code            = size;
    d.source_fixed         = sfix;
    d.dest_fixed           = dfix;
    d.continuous           = cont;
    d.request_select       = sel;
    d.source_addr_out      = saddr;
    d.dest_addr_out        = daddr;
    return d;
  endfunction

  task automatic add_row(input dtdb_req_t rq, input logic typed, input dtdb_result_t want);
    directed_row_t row;
    row.rq = rq;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random requests. Most are well formed with random content, so that they
  // reach the divider and the factoring walk; some aim at one check each,
  // and the rest are noise over the fields that the checks look at.
  // ---------------------------------------------------------------------------
  function automatic dtdb_req_t random_request();
    dtdb_req_t   rq;
    int unsigned w;
    int unsigned elems;
    int unsigned pick;
    int unsigned odd_w;
    w = 1 << $urandom_range(0, 2);
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      elems = $urandom_range(1, FRAME_LIMIT);
    end else if (pick < 17) begin
      elems = $urandom_range(1, FRAME_LIMIT) * $urandom_range(1, FRAME_LIMIT);
    end else begin
      elems = $urandom_range(FRAME_LIMIT + 1, 1 << 17);
    end
    rq.num_blocks         = SINGLE_BLOCK;
    rq.extra_features     = 1'b0;
    rq.transfer_direction = 3'($urandom_range(DIR_MEM_TO_MEM, DIR_PERIPH_TO_MEM));
    rq.source_width       = 8'(w);
    rq.dest_width         = 8'(w);
    rq.block_bytes        = 32'(w * elems);
    rq.source_adjust      = $urandom_range(0, 1) ? ADJ_FIXED : ADJ_INC;
    rq.dest_adjust        = $urandom_range(0, 1) ? ADJ_FIXED : ADJ_INC;
    rq.cyclic             = 1'($urandom);
    rq.request_slot       = 8'($urandom);
    rq.source_addr        = $urandom;
    rq.dest_addr          = $urandom;

    pick = $urandom_range(0, 99);
    if (pick >= 85) begin
      rq.num_blocks = $urandom_range(0, 1) ? SINGLE_BLOCK : 4'($urandom);
      rq.extra_features = ($urandom_range(0, 3) == 0);
      rq.transfer_direction = 3'($urandom);
      rq.source_width = 8'($urandom);
      rq.dest_width = $urandom_range(0, 1) ? rq.source_width : 8'($urandom);
      rq.block_bytes = $urandom;
      rq.source_adjust = 2'($urandom);
      rq.dest_adjust = 2'($urandom);
    end else if (pick >= 70) begin
      case ($urandom_range(0, 7))
        0: rq.num_blocks = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(2, 15));
        1: rq.extra_features = 1'b1;
        2: rq.transfer_direction = 3'($urandom_range(DIR_PERIPH_TO_MEM + 1, 7));
        3: begin
          if ($urandom_range(0, 3) == 0) begin
            rq.source_width = 8'd0;
            rq.dest_width = 8'd0;
          end else begin
            rq.dest_width = rq.source_width ^ 8'($urandom_range(1, 255));
          end
        end
        4: begin
          if (w == 1 || $urandom_range(0, 3) == 0) begin
            rq.block_bytes = 32'd0;
          end else begin
            rq.block_bytes = rq.block_bytes + 32'($urandom_range(1, w - 1));
          end
        end
        5: begin
          odd_w = $urandom_range(0, 255);
          rq.source_width = 8'(odd_w);
          rq.dest_width = 8'(odd_w);
          rq.block_bytes = 32'(odd_w * $urandom_range(1, 600));
        end
        6: rq.source_adjust = $urandom_range(0, 1) ? ADJ_DEC : ADJ_RSVD;
        default: rq.dest_adjust = $urandom_range(0, 1) ? ADJ_DEC : ADJ_RSVD;
      endcase
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Inputs change at the falling edge. A transaction is taken at the
  // rising edge where start is high and busy is low. Start stays high between
  // back-to-back transactions so that it is never dropped and raised in the
  // same step. Each request waits a random gap first, except in stretches where
  // the sender runs flat out.
  // ---------------------------------------------------------------------------
  task automatic issue(input dtdb_req_t rq, input dtdb_result_t want);
    int unsigned gap;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) steady_left = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req <= rq;
    do @(posedge clk); while (busy);
    pending_descriptors.push_back(want);
    @(negedge clk);
  endtask

  // Hold off new requests until every owed descriptor has come back. At least
  // one falling edge passes, so start is never lowered and raised in one step.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_descriptors.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Checker. A result is shown for exactly one cycle with done high and is
  // taken at the rising edge that ends that cycle. Each field is compared with
  // the oldest owed descriptor.
  // ---------------------------------------------------------------------------
  function automatic string field_diffs(input dtdb_result_t want, input dtdb_result_t got);
    string s;
    s = "";
    if (got.status !== want.status) s = {s, " status"};
    if (got.frame_count_less_one !== want.frame_count_less_one) s = {s, " frame_count_less_one"};
    if (got.pack_count_less_one !== want.pack_count_less_one) s = {s, " pack_count_less_one"};
    if (got.packed_mode !== want.packed_mode) s = {s, " packed_mode"};
    if (got.size_code !== want.size_code) s = {s, " size_code"};
    if (got.source_fixed !== want.source_fixed) s = {s, " source_fixed"};
    if (got.dest_fixed !== want.dest_fixed) s = {s, " dest_fixed"};
    if (got.continuous !== want.continuous) s = {s, " continuous"};
    if (got.request_select !== want.request_select) s = {s, " request_select"};
    if (got.source_addr_out !== want.source_addr_out) s = {s, " source_addr_out"};
    if (got.dest_addr_out !== want.dest_addr_out) s = {s, " dest_addr_out"};
    return s;
  endfunction

  task automatic note_mismatch(input string what, input dtdb_result_t want,
                               input dtdb_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] descriptor mismatch:%s", $realtime, what);
      $display("  expected %h", want);
      $display("  actual   %h", got);
    end
  endtask

  dtdb_result_t owed;
  string        diffs;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_descriptors.size() == 0) begin
        note_mismatch(" result with no request outstanding", '0, result);
      end else begin
        owed = pending_descriptors.pop_front();
        diffs = field_diffs(owed, result);
        if (diffs != "") note_mismatch(diffs, owed, result);
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("[%0t] watchdog expired with %0d descriptors outstanding", $realtime,
               pending_descriptors.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, a full drain, random traffic with a
  // drain in the middle, then the final drain and a quiet tail.
  // ---------------------------------------------------------------------------
  initial begin
    dtdb_result_t want;
    rst = 1'b1;
    start = 1'b0;
    req = '0;

    // Each check in turn, with the first failing check deciding the status.
    add_row(req_of(4'd0, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd4, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    // Block count wins over the feature flag.
    add_row(req_of(4'd15, 1'b1, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd4, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    add_row(req_of(SINGLE_BLOCK, 1'b1, 3'd7, 8'd1, 8'd1, 32'd4, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_PERIPH_TO_MEM + 3'd1, 8'd1, 8'd1, 32'd4,
                   ADJ_INC, ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b1,
            rejected(ST_UNSUPPORTED));
    add_row(req_of(SINGLE_BLOCK, 1'b0, 3'd7, 8'd4, 8'd4, 32'd16, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    // Zero width, then mismatched widths.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd0, 8'd0, 32'd4, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd2, 32'd8, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    // Empty transfer, then a byte count that is not a whole number of elements.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd0, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd4, 32'd6, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    // A prime element count just above the frame limit cannot be split.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd257, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    // Widths other than byte, halfword and word.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd3, 8'd3, 32'd9, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd255, 8'd255, 32'd65025, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_INVALID));
    // Decrement and the reserved adjust mode.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd4, 32'd4, ADJ_DEC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd4, 32'd4, ADJ_FIXED,
                   ADJ_RSVD, 1'b0, 8'h00, 32'h0, 32'h0), 1'b1, rejected(ST_UNSUPPORTED));
    // Good requests at the edges of single-frame mode and of the pass-through fields.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd1, ADJ_INC, ADJ_INC,
                   1'b0, 8'h00, 32'h0, 32'h0), 1'b1,
            accepted_desc(8'd0, SIZE_BYTE, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 32'h0));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_PERIPH_TO_MEM, 8'd1, 8'd1, 32'd256, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b1,
            accepted_desc(8'd255, SIZE_BYTE, 1'b0, 1'b0, 1'b0, 5'd0, 32'h0, 32'h0));
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_PERIPH, 8'd2, 8'd2, 32'd2, ADJ_FIXED,
                   ADJ_FIXED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
            accepted_desc(8'd0, SIZE_HALF, 1'b1, 1'b1, 1'b1, 5'd31, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
    // The rest go through the predictor: word transfers, pack mode at its largest, a
    // small-frame split, counts far beyond any split or just unsplittable, a bad width.
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd4, 32'd1024, ADJ_INC,
                   ADJ_FIXED, 1'b0, 8'h15, 32'h1000_0000, 32'h2000_0000), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_PERIPH, 8'd1, 8'd1, 32'd65536, ADJ_INC,
                   ADJ_INC, 1'b1, 8'h3A, 32'h8000_0001, 32'h7FFF_FFFE), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_PERIPH_TO_MEM, 8'd2, 8'd2, 32'd600, ADJ_FIXED,
                   ADJ_INC, 1'b0, 8'h20, 32'hA5A5_A5A5, 32'h5A5A_5A5A), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'hFFFF_FFFF, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd4, 8'd4, 32'hFFFF_FFFC, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd1, 8'd1, 32'd514, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b0, '0);
    add_row(req_of(SINGLE_BLOCK, 1'b0, DIR_MEM_TO_MEM, 8'd128, 8'd128, 32'd1024, ADJ_INC,
                   ADJ_INC, 1'b0, 8'h00, 32'h0, 32'h0), 1'b0, '0);

    // Synchronous reset, released at a falling edge.
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : build_descriptor(directed_rows[i].rq);
      issue(directed_rows[i].rq, want);
    end
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      dtdb_req_t rq;
      rq = random_request();
      issue(rq, build_descriptor(rq));
      // Once in the middle the sender waits for the block to empty out.
      if (n == RANDOM_ITEMS / 2) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
